// ===== src/gbm_pkg.sv =====
// Shared types and constants of the 3x3 Gaussian blur core.
package gbm_pkg;

    localparam int PIX_W        = 8;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int WEIGHT_W     = 8;
    localparam int SHIFT_W      = 4;
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int SUM_W        = PIX_W + 2;
    localparam int PROD_W       = SUM_W + WEIGHT_W;
    localparam int CPROD_W      = PIX_W + WEIGHT_W;
    localparam int TOTAL_W      = PROD_W + 3;
    localparam int NUM_KINDS    = 4;

    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [WEIGHT_W-1:0]     RST_WEIGHT_CORNER = 8'd1;
    localparam logic [WEIGHT_W-1:0]     RST_WEIGHT_EDGE   = 8'd2;
    localparam logic [WEIGHT_W-1:0]     RST_WEIGHT_CENTER = 8'd4;
    localparam logic [SHIFT_W-1:0]      RST_WEIGHT_SHIFT  = 4'd4;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_WEIGHT_CORNER = 3'd2,
        REG_WEIGHT_EDGE   = 3'd3,
        REG_WEIGHT_CENTER = 3'd4,
        REG_WEIGHT_SHIFT  = 3'd5
    } reg_index_t;

    // result kinds of one item, in emission order
    typedef enum logic [1:0] {
        KIND_ABOVE_PREV = 2'd0,
        KIND_ABOVE_LAST = 2'd1,
        KIND_ROW_PREV   = 2'd2,
        KIND_ROW_LAST   = 2'd3
    } kind_t;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  image_width;
        logic [HEIGHT_REG_W-1:0] image_height;
        logic [WEIGHT_W-1:0]     weight_corner;
        logic [WEIGHT_W-1:0]     weight_edge;
        logic [WEIGHT_W-1:0]     weight_center;
        logic [SHIFT_W-1:0]      weight_shift;
    } cfg_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef struct packed {
        column_t                left;
        column_t                cen;
        column_t                cur;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [NUM_KINDS-1:0]   mask;
    } job_t;

endpackage

// ===== src/gbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gbm_cfg.sv =====
// APB register file holding frame size and kernel weights.
module gbm_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gbm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [gbm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [gbm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output gbm_pkg::cfg_t                      cfg
);
    import gbm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr;

    assign idx    = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (idx)
                REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = pwdata[HEIGHT_REG_W-1:0];
                REG_WEIGHT_CORNER: cfg_next.weight_corner = pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_EDGE:   cfg_next.weight_edge   = pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_CENTER: cfg_next.weight_center = pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_SHIFT:  cfg_next.weight_shift  = pwdata[SHIFT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= RST_IMAGE_WIDTH;
            cfg_reg.image_height  <= RST_IMAGE_HEIGHT;
            cfg_reg.weight_corner <= RST_WEIGHT_CORNER;
            cfg_reg.weight_edge   <= RST_WEIGHT_EDGE;
            cfg_reg.weight_center <= RST_WEIGHT_CENTER;
            cfg_reg.weight_shift  <= RST_WEIGHT_SHIFT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_IMAGE_WIDTH:   prdata = CFG_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:  prdata = CFG_DATA_W'(cfg_reg.image_height);
            REG_WEIGHT_CORNER: prdata = CFG_DATA_W'(cfg_reg.weight_corner);
            REG_WEIGHT_EDGE:   prdata = CFG_DATA_W'(cfg_reg.weight_edge);
            REG_WEIGHT_CENTER: prdata = CFG_DATA_W'(cfg_reg.weight_center);
            REG_WEIGHT_SHIFT:  prdata = CFG_DATA_W'(cfg_reg.weight_shift);
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== src/gbm_line.sv =====
// Line memories, position counters and window columns; forms one job per item.
module gbm_line (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gbm_pkg::cfg_t          cfg,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  gbm_pkg::pix_t          s_pixel,
    output logic                   job_valid,
    input  logic                   job_ready,
    output gbm_pkg::job_t          job
);
    import gbm_pkg::*;

    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    last_col, last_row;
    logic                    accept, s1_go;

    logic                    s1_valid_reg, s1_valid_next;
    pix_t                    s1_pixel_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic [ROW_W-1:0]        s1_row_reg;
    logic                    s1_last_col_reg, s1_last_row_reg;
    logic                    byp_valid_reg, byp_valid_next;
    pix_t                    byp_above_reg, byp_middle_reg;

    pix_t                    above_rdata, middle_rdata;
    pix_t                    top_raw, mid_raw;
    column_t                 cur, cen, left;
    column_t                 win_left_reg, win_cen_reg;

    always_comb begin
        if (cfg.image_width == '0) begin
            w_eff = WIDTH_REG_W'(1);
        end else if (cfg.image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            w_eff = cfg.image_width;
        end
        if (cfg.image_height == '0) begin
            h_eff = HEIGHT_REG_W'(1);
        end else if (cfg.image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_eff = cfg.image_height;
        end
    end

    assign last_col = (WIDTH_REG_W'(col_reg) + WIDTH_REG_W'(1)) >= w_eff;
    assign last_row = (HEIGHT_REG_W'(row_reg) + HEIGHT_REG_W'(1)) >= h_eff;

    assign s_tready = !s1_valid_reg || job_ready;
    assign accept   = s_tvalid && s_tready;
    assign s1_go    = s1_valid_reg && job_ready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // forward the write-back that lands on the same edge as the read
    assign byp_valid_next = accept ? (s1_go && (s1_col_reg == col_reg)) : byp_valid_reg;
    assign s1_valid_next  = accept || (s1_valid_reg && !s1_go);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg    <= s_pixel;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            byp_above_reg   <= mid_raw;
            byp_middle_reg  <= s1_pixel_reg;
        end
    end

    gbm_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_above_ram (
        .aclk  (aclk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (mid_raw),
        .re    (accept),
        .raddr (col_reg),
        .rdata (above_rdata)
    );

    gbm_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .aclk  (aclk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (middle_rdata)
    );

    assign top_raw = byp_valid_reg ? byp_above_reg  : above_rdata;
    assign mid_raw = byp_valid_reg ? byp_middle_reg : middle_rdata;

    always_comb begin
        cur.bot = s1_pixel_reg;
        if (s1_row_reg == '0) begin
            cur.top = s1_pixel_reg;
            cur.mid = s1_pixel_reg;
        end else if (s1_row_reg == ROW_W'(1)) begin
            cur.top = mid_raw;
            cur.mid = mid_raw;
        end else begin
            cur.top = top_raw;
            cur.mid = mid_raw;
        end
        cen  = (s1_col_reg != '0) ? win_cen_reg : cur;
        left = (s1_col_reg > COL_W'(1)) ? win_left_reg : cen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg <= '0;
            win_cen_reg  <= '0;
        end else if (s1_go) begin
            win_left_reg <= win_cen_reg;
            win_cen_reg  <= cur;
        end
    end

    always_comb begin
        job.left = left;
        job.cen  = cen;
        job.cur  = cur;
        job.row  = s1_row_reg;
        job.col  = s1_col_reg;
        job.mask[KIND_ABOVE_PREV] = (s1_row_reg != '0) && (s1_col_reg != '0);
        job.mask[KIND_ABOVE_LAST] = (s1_row_reg != '0) && s1_last_col_reg;
        job.mask[KIND_ROW_PREV]   = s1_last_row_reg && (s1_col_reg != '0);
        job.mask[KIND_ROW_LAST]   = s1_last_row_reg && s1_last_col_reg;
    end

    assign job_valid = s1_valid_reg;

endmodule

// ===== src/gbm_emit.sv =====
// Walks the results of one job and runs the weighted sum, rounding and clamp.
module gbm_emit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gbm_pkg::cfg_t             cfg,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  gbm_pkg::job_t             job,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output gbm_pkg::pix_t             m_pixel,
    output logic [gbm_pkg::ROW_W-1:0] m_row,
    output logic [gbm_pkg::COL_W-1:0] m_col,
    output logic                      m_last,
    output logic                      m_done
);
    import gbm_pkg::*;

    job_t                 jb_reg;
    logic [NUM_KINDS-1:0] mask_reg, mask_next, remaining;
    kind_t                kind;
    logic                 pipe_en, busy, emit, last_adv, load;
    column_t              col_x, col_y, col_z;

    logic                 a_valid_reg;
    logic [SUM_W-1:0]     a_corner_reg, a_side_reg;
    pix_t                 a_center_reg;
    logic [ROW_W-1:0]     a_row_reg;
    logic [COL_W-1:0]     a_col_reg;
    logic                 a_last_reg, a_done_reg;

    logic                 b_valid_reg;
    logic [PROD_W-1:0]    b_corner_reg, b_side_reg;
    logic [CPROD_W-1:0]   b_center_reg;
    logic [ROW_W-1:0]     b_row_reg;
    logic [COL_W-1:0]     b_col_reg;
    logic                 b_last_reg, b_done_reg;

    logic                 m_valid_reg;
    pix_t                 m_pixel_reg, m_pixel_next;
    logic [ROW_W-1:0]     m_row_reg;
    logic [COL_W-1:0]     m_col_reg;
    logic                 m_last_reg, m_done_reg;

    logic [TOTAL_W-1:0]   rnd, total, shifted;

    assign pipe_en = !m_valid_reg || m_tready;
    assign busy    = mask_reg != '0;

    always_comb begin
        if (mask_reg[KIND_ABOVE_PREV]) begin
            kind = KIND_ABOVE_PREV;
        end else if (mask_reg[KIND_ABOVE_LAST]) begin
            kind = KIND_ABOVE_LAST;
        end else if (mask_reg[KIND_ROW_PREV]) begin
            kind = KIND_ROW_PREV;
        end else begin
            kind = KIND_ROW_LAST;
        end
    end

    assign remaining = mask_reg & ~(NUM_KINDS'(1) << kind);
    assign emit      = busy && pipe_en;
    assign last_adv  = emit && (remaining == '0);
    assign job_ready = !busy || last_adv;
    assign load      = job_valid && job_ready;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = job.mask;
        end else if (emit) begin
            mask_next = remaining;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            jb_reg <= job;
        end
    end

    // kind bit 0 shifts the window right, bit 1 drops the top row
    always_comb begin
        col_x = kind[0] ? jb_reg.cen : jb_reg.left;
        col_y = kind[0] ? jb_reg.cur : jb_reg.cen;
        col_z = jb_reg.cur;
        if (kind[1]) begin
            col_x.top = col_x.mid;
            col_x.mid = col_x.bot;
            col_y.top = col_y.mid;
            col_y.mid = col_y.bot;
            col_z.top = col_z.mid;
            col_z.mid = col_z.bot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= emit;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_corner_reg <= SUM_W'(col_x.top) + SUM_W'(col_x.bot)
                          + SUM_W'(col_z.top) + SUM_W'(col_z.bot);
            a_side_reg   <= SUM_W'(col_x.mid) + SUM_W'(col_z.mid)
                          + SUM_W'(col_y.top) + SUM_W'(col_y.bot);
            a_center_reg <= col_y.mid;
            a_row_reg    <= kind[1] ? jb_reg.row : jb_reg.row - ROW_W'(1);
            a_col_reg    <= kind[0] ? jb_reg.col : jb_reg.col - COL_W'(1);
            a_last_reg   <= remaining == '0;
            a_done_reg   <= kind == KIND_ROW_LAST;

            b_corner_reg <= PROD_W'(a_corner_reg) * PROD_W'(cfg.weight_corner);
            b_side_reg   <= PROD_W'(a_side_reg) * PROD_W'(cfg.weight_edge);
            b_center_reg <= CPROD_W'(a_center_reg) * CPROD_W'(cfg.weight_center);
            b_row_reg    <= a_row_reg;
            b_col_reg    <= a_col_reg;
            b_last_reg   <= a_last_reg;
            b_done_reg   <= a_done_reg;

            m_pixel_reg  <= m_pixel_next;
            m_row_reg    <= b_row_reg;
            m_col_reg    <= b_col_reg;
            m_last_reg   <= b_last_reg;
            m_done_reg   <= b_done_reg;
        end
    end

    always_comb begin
        if (cfg.weight_shift == '0) begin
            rnd = '0;
        end else begin
            rnd = TOTAL_W'(1) << (cfg.weight_shift - SHIFT_W'(1));
        end
        total   = TOTAL_W'(b_corner_reg) + TOTAL_W'(b_side_reg)
                + TOTAL_W'(b_center_reg) + rnd;
        shifted = total >> cfg.weight_shift;
        if (shifted > TOTAL_W'({PIX_W{1'b1}})) begin
            m_pixel_next = {PIX_W{1'b1}};
        end else begin
            m_pixel_next = shifted[PIX_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_pixel  = m_pixel_reg;
    assign m_row    = m_row_reg;
    assign m_col    = m_col_reg;
    assign m_last   = m_last_reg;
    assign m_done   = m_done_reg;

endmodule

// ===== src/gaussian_blur_3x3_mirror_core.sv =====
// Top level of the streaming 3x3 Gaussian blur with repeated-edge borders.
// An item passes the line stage and job registers, then the sum, product and output registers.
// Throughput: one item per cycle while the output is not stalled and each item gives at
// most one result; a row-end or last-row item gives up to 4 results and holds the input meanwhile.
// Unstalled, the output moves one result per cycle through a three-stage sum/multiply/round pipe.
// Reset (synchronous, aresetn low) clears counters, window and valids and reloads config defaults; line memories stay.
module gaussian_blur_3x3_mirror_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // pixel_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // pixel_out, out_row, out_col
    output logic                               m_tlast,   // run_last
    output logic [0:0]                         m_tuser,   // frame_done
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gbm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [gbm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [gbm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import gbm_pkg::*;

    cfg_t             cfg;
    job_t             job;
    logic             job_valid, job_ready;
    pix_t             m_pixel;
    logic [ROW_W-1:0] m_row;
    logic [COL_W-1:0] m_col;
    logic             m_done;

    gbm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gbm_line u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (s_tdata[PIX_W-1:0]),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    gbm_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_pixel   (m_pixel),
        .m_row     (m_row),
        .m_col     (m_col),
        .m_last    (m_tlast),
        .m_done    (m_done)
    );

    assign m_tdata = {2'b00, m_col, m_row, m_pixel};
    assign m_tuser = m_done;

endmodule

// ===== src/gbm_check.sv =====
// Port-level assertions for the blur core, bound to the top level.
module gbm_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end result not last of its item");

    a_done_bottom_right: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tready |=> !(m_tvalid && m_tuser[0] && !m_tlast))
        else $error("frame end marking inconsistent");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && pready)
        else $error("output valid right after reset");

endmodule

bind gaussian_blur_3x3_mirror_core gbm_check u_check (.*);
